>>> hdl/mtl_pkg.sv
// Shared types and constants for the markup token lexer.
`default_nettype none

package mtl_pkg;

  // Lexer state: what is held back, if anything
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_SIGN = 3'd1,
    ST_ZERO = 3'd2,
    ST_INT  = 3'd3,
    ST_DOT  = 3'd4,
    ST_FRAC = 3'd5,
    ST_STR  = 3'd6,
    ST_HALT = 3'd7
  } lx_state_t;

  typedef enum logic [2:0] {
    KIND_NUM   = 3'd0,
    KIND_STR   = 3'd1,
    KIND_OPEN  = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_QUOTE = 3'd4,
    KIND_SLASH = 3'd5
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_LEAD0   = 2'd1,
    ERR_DOT     = 2'd2,
    ERR_INVALID = 2'd3
  } err_code_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] ch;
    logic       last;
    err_code_t  err;
  } tok_res_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

endpackage

`default_nettype wire

>>> hdl/markup_token_lexer.sv
// Markup token lexer: byte stream in, one token character per result out.
//
//   channel  | dir | tdata              | tuser                          | tlast
//   ---------+-----+--------------------+--------------------------------+-------------
//   s_axis   | in  | [7:0] byte_in      | -                              | end_of_input
//   m_axis   | out | [7:0] token_char   | [2:0] token_kind, [4:3] error  | last_in_token
//
// One input item accepted per cycle while s_axis_tready is high. Each item yields zero,
// one or two results, which go into a four-entry result queue; results leave one per
// cycle while m_axis_tready is high; an item's results enter the queue as it is taken.
// s_axis_tready is high while the queue holds two results or fewer, so once three
// results wait on a stalled m_axis, s_axis is held off until one leaves.
// rst (synchronous) returns the lexer to idle, drops the held character and
// empties the queue. After an error result the lexer halts until rst.
`default_nettype none

module markup_token_lexer
  import mtl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_in
  input  wire logic       s_axis_tlast,   // end_of_input
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] token_char
  output logic [4:0]      m_axis_tuser,   // [2:0] token_kind, [4:3] error_code
  output logic            m_axis_tlast    // last_in_token
);

  // lexer state and held-back character
  lx_state_t  state, state_next;
  logic [7:0] held, held_next;

  // result queue
  tok_res_t        queue [QDEPTH];
  logic [QAW-1:0]  wr_ptr, rd_ptr;
  logic [QAW:0]    count, count_next;

  logic       in_acc, out_acc;
  logic [7:0] c;
  logic       eoi, c_digit, c_upper;

  // what a character does when nothing is held
  logic       idle_emit;
  tok_res_t   idle_res;
  lx_state_t  idle_st;
  logic [7:0] idle_held;

  // results of this item
  tok_res_t   res0, res1;
  logic [1:0] n_res;
  tok_kind_t  cur_kind;

  function automatic tok_res_t mk_res(tok_kind_t k, logic [7:0] ch, logic last,
                                      err_code_t e);
    tok_res_t r;
    r.kind = k;
    r.ch   = ch;
    r.last = last;
    r.err  = e;
    return r;
  endfunction

  assign c       = s_axis_tdata;
  assign eoi     = s_axis_tlast;
  assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign c_upper = (c >= CH_UA) && (c <= CH_UZ);

  assign s_axis_tready = (count < (QAW+1)'(QDEPTH - 1));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count != '0);
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  assign cur_kind = (state == ST_STR) ? KIND_STR : KIND_NUM;

  // character seen from idle
  always_comb begin
    idle_emit = 1'b0;
    idle_res  = mk_res(KIND_NUM, c, 1'b1, ERR_NONE);
    idle_st   = ST_IDLE;
    idle_held = '0;
    if (c == CH_SPACE || c == CH_NL) begin
      idle_st = ST_IDLE;
    end else if (c == CH_MINUS) begin
      idle_st   = ST_SIGN;
      idle_held = c;
    end else if (c == CH_ZERO) begin
      idle_st   = ST_ZERO;
      idle_held = c;
    end else if (c_digit) begin
      idle_st   = ST_INT;
      idle_held = c;
    end else if (c_upper) begin
      idle_st   = ST_STR;
      idle_held = c;
    end else if (c == CH_LT) begin
      idle_emit = 1'b1;
      idle_res  = mk_res(KIND_OPEN, c, 1'b1, ERR_NONE);
    end else if (c == CH_GT) begin
      idle_emit = 1'b1;
      idle_res  = mk_res(KIND_CLOSE, c, 1'b1, ERR_NONE);
    end else if (c == CH_QUOTE) begin
      idle_emit = 1'b1;
      idle_res  = mk_res(KIND_QUOTE, c, 1'b1, ERR_NONE);
    end else if (c == CH_SLASH) begin
      idle_emit = 1'b1;
      idle_res  = mk_res(KIND_SLASH, c, 1'b1, ERR_NONE);
    end else begin
      idle_emit = 1'b1;
      idle_res  = mk_res(KIND_NUM, c, 1'b0, ERR_INVALID);
      idle_st   = ST_HALT;
    end
  end

  // next state and results for one item
  always_comb begin
    state_next = state;
    held_next  = held;
    n_res      = 2'd0;
    res0       = mk_res(cur_kind, held, 1'b0, ERR_NONE);
    res1       = idle_res;

    if (state == ST_HALT) begin
      n_res = 2'd0;
    end else if (eoi) begin
      // flush held char; a dangling dot is an error
      if (state == ST_DOT) begin
        res0       = mk_res(KIND_NUM, 8'h00, 1'b0, ERR_DOT);
        n_res      = 2'd1;
        state_next = ST_HALT;
      end else begin
        res0       = mk_res(cur_kind, held, 1'b1, ERR_NONE);
        n_res      = (state != ST_IDLE) ? 2'd1 : 2'd0;
        state_next = ST_IDLE;
      end
      held_next = '0;
    end else begin
      case (state)
        ST_IDLE: begin
          res0       = idle_res;
          n_res      = {1'b0, idle_emit};
          state_next = idle_st;
          held_next  = idle_held;
        end
        ST_SIGN, ST_ZERO, ST_INT, ST_FRAC, ST_STR: begin
          if (state == ST_ZERO && c_digit) begin
            res0       = mk_res(KIND_NUM, c, 1'b0, ERR_LEAD0);
            n_res      = 2'd1;
            state_next = ST_HALT;
            held_next  = '0;
          end else if (state == ST_STR && (c_upper || c == CH_MINUS)) begin
            n_res      = 2'd1;
            state_next = ST_STR;
            held_next  = c;
          end else if (state != ST_STR && c_digit) begin
            n_res      = 2'd1;
            held_next  = c;
            if (state == ST_FRAC) begin
              state_next = ST_FRAC;
            end else if (state == ST_SIGN && c == CH_ZERO) begin
              state_next = ST_ZERO;
            end else begin
              state_next = ST_INT;
            end
          end else if (state != ST_STR && state != ST_FRAC && c == CH_DOT) begin
            n_res      = 2'd1;
            state_next = ST_DOT;
            held_next  = c;
          end else begin
            // token ends here; the new character starts afresh
            res0       = mk_res(cur_kind, held, 1'b1, ERR_NONE);
            n_res      = idle_emit ? 2'd2 : 2'd1;
            state_next = idle_st;
            held_next  = idle_held;
          end
        end
        ST_DOT: begin
          if (c_digit) begin
            n_res      = 2'd1;
            state_next = ST_FRAC;
            held_next  = c;
          end else begin
            res0       = mk_res(KIND_NUM, c, 1'b0, ERR_DOT);
            n_res      = 2'd1;
            state_next = ST_HALT;
            held_next  = '0;
          end
        end
        default: begin
          n_res = 2'd0;
        end
      endcase
    end
  end

  always_comb begin
    count_next = count;
    if (in_acc) begin
      count_next = count_next + (QAW+1)'(n_res);
    end
    if (out_acc) begin
      count_next = count_next - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      held   <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_acc) begin
        state  <= state_next;
        held   <= held_next;
        wr_ptr <= wr_ptr + QAW'(n_res);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (in_acc && n_res == 2'd2) begin
      queue[wr_ptr + QAW'(1)] <= res1;
    end
  end

  assign m_axis_tdata = queue[rd_ptr].ch;
  assign m_axis_tuser = {queue[rd_ptr].err, queue[rd_ptr].kind};
  assign m_axis_tlast = queue[rd_ptr].last;

endmodule

`default_nettype wire

>>> hdl/mtl_checker.sv
// Port-level checks for the markup token lexer, bound to the top level.
`default_nettype none

module mtl_checker
  import mtl_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic       s_axis_tlast,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [4:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  // an error result is never a token end and always carries the number kind
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[4:3] != ERR_NONE)
      |-> !m_axis_tlast && (m_axis_tuser[2:0] == KIND_NUM))
    else $error("error result with tlast or non-number kind");

  // nothing follows an error until reset
  a_halt: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser[4:3] != ERR_NONE)
      |=> !m_axis_tvalid)
    else $error("result after error");

  // an open-bracket token carries its own character and ends at once
  a_open: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[2:0] == KIND_OPEN)
      |-> m_axis_tlast && (m_axis_tdata == CH_LT))
    else $error("bad open bracket result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
          && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // an accepted input item is fully driven
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> !$isunknown({s_axis_tdata, s_axis_tlast}))
    else $error("unknown input item accepted");

endmodule

bind markup_token_lexer mtl_checker u_mtl_checker (.*);

`default_nettype wire

>>> tb/lexer_checker.sv
// Watches both streams of the markup token lexer, predicts each token character and compares.
module lexer_checker
  import mtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic [4:0] m_axis_tuser,
  input  logic       m_axis_tlast,
  output int         pending_count,
  output int         fault_count
);

  lx_state_t  lex_state;
  logic [7:0] lex_held;
  tok_res_t   expected_tokens[$];

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_upper(logic [7:0] c);
    return c >= CH_UA && c <= CH_UZ;
  endfunction

  task automatic put_token(tok_kind_t k, logic [7:0] c, logic l, err_code_t e);
    tok_res_t r;
    r.kind = k;
    r.ch   = c;
    r.last = l;
    r.err  = e;
    expected_tokens.push_back(r);
  endtask

  // error: one result, held char dropped, lexer stuck until reset
  task automatic halt_on(logic [7:0] c, err_code_t e);
    put_token(KIND_NUM, c, 1'b0, e);
    lex_state = ST_HALT;
    lex_held  = '0;
  endtask

  task automatic hold(lx_state_t s, logic [7:0] c);
    lex_state = s;
    lex_held  = c;
  endtask

  // character with nothing held back
  task automatic start_fresh(logic [7:0] c);
    lex_state = ST_IDLE;
    lex_held  = '0;
    if (c == CH_SPACE || c == CH_NL) begin
    end else if (c == CH_MINUS) begin
      hold(ST_SIGN, c);
    end else if (c == CH_ZERO) begin
      hold(ST_ZERO, c);
    end else if (is_digit(c)) begin
      hold(ST_INT, c);
    end else if (is_upper(c)) begin
      hold(ST_STR, c);
    end else if (c == CH_LT) begin
      put_token(KIND_OPEN, c, 1'b1, ERR_NONE);
    end else if (c == CH_GT) begin
      put_token(KIND_CLOSE, c, 1'b1, ERR_NONE);
    end else if (c == CH_QUOTE) begin
      put_token(KIND_QUOTE, c, 1'b1, ERR_NONE);
    end else if (c == CH_SLASH) begin
      put_token(KIND_SLASH, c, 1'b1, ERR_NONE);
    end else begin
      halt_on(c, ERR_INVALID);
    end
  endtask

  task automatic lex_byte(logic [7:0] c, logic eoi);
    tok_kind_t k;
    k = (lex_state == ST_STR) ? KIND_STR : KIND_NUM;
    if (lex_state == ST_HALT) return;
    if (eoi) begin
      if (lex_state == ST_DOT) begin
        halt_on(8'h00, ERR_DOT);
        return;
      end
      if (lex_state != ST_IDLE) put_token(k, lex_held, 1'b1, ERR_NONE);
      lex_state = ST_IDLE;
      lex_held  = '0;
      return;
    end
    case (lex_state)
      ST_IDLE: begin
        start_fresh(c);
      end
      ST_SIGN: begin
        if (c == CH_ZERO) begin
          put_token(KIND_NUM, lex_held, 1'b0, ERR_NONE);
          hold(ST_ZERO, c);
        end else if (is_digit(c)) begin
          put_token(KIND_NUM, lex_held, 1'b0, ERR_NONE);
          hold(ST_INT, c);
        end else if (c == CH_DOT) begin
          put_token(KIND_NUM, lex_held, 1'b0, ERR_NONE);
          hold(ST_DOT, c);
        end else begin
          put_token(KIND_NUM, lex_held, 1'b1, ERR_NONE);
          start_fresh(c);
        end
      end
      ST_ZERO: begin
        if (is_digit(c)) begin
          halt_on(c, ERR_LEAD0);
        end else if (c == CH_DOT) begin
          put_token(KIND_NUM, lex_held, 1'b0, ERR_NONE);
          hold(ST_DOT, c);
        end else begin
          put_token(KIND_NUM, lex_held, 1'b1, ERR_NONE);
          start_fresh(c);
        end
      end
      ST_INT: begin
        if (is_digit(c)) begin
          put_token(KIND_NUM, lex_held, 1'b0, ERR_NONE);
          hold(ST_INT, c);
        end else if (c == CH_DOT) begin
          put_token(KIND_NUM, lex_held, 1'b0, ERR_NONE);
          hold(ST_DOT, c);
        end else begin
          put_token(KIND_NUM, lex_held, 1'b1, ERR_NONE);
          start_fresh(c);
        end
      end
      ST_DOT: begin
        if (is_digit(c)) begin
          put_token(KIND_NUM, lex_held, 1'b0, ERR_NONE);
          hold(ST_FRAC, c);
        end else begin
          halt_on(c, ERR_DOT);
        end
      end
      ST_FRAC: begin
        if (is_digit(c)) begin
          put_token(KIND_NUM, lex_held, 1'b0, ERR_NONE);
          hold(ST_FRAC, c);
        end else begin
          put_token(KIND_NUM, lex_held, 1'b1, ERR_NONE);
          start_fresh(c);
        end
      end
      default: begin
        if (is_upper(c) || c == CH_MINUS) begin
          put_token(KIND_STR, lex_held, 1'b0, ERR_NONE);
          hold(ST_STR, c);
        end else begin
          put_token(KIND_STR, lex_held, 1'b1, ERR_NONE);
          start_fresh(c);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    tok_res_t want;
    if (rst) begin
      lex_state = ST_IDLE;
      lex_held  = '0;
      expected_tokens.delete();
    end else begin
      // results first: none can stem from an item taken at this same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected result: token_char %h tuser %h last %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fault_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (want.kind !== m_axis_tuser[2:0]) begin
            $error("token_kind: expected %0d, actual %0d", want.kind, m_axis_tuser[2:0]);
            fault_count++;
          end
          if (want.ch !== m_axis_tdata) begin
            $error("token_char: expected %h, actual %h", want.ch, m_axis_tdata);
            fault_count++;
          end
          if (want.last !== m_axis_tlast) begin
            $error("last_in_token: expected %b, actual %b", want.last, m_axis_tlast);
            fault_count++;
          end
          if (want.err !== m_axis_tuser[4:3]) begin
            $error("error_code: expected %0d, actual %0d", want.err, m_axis_tuser[4:3]);
            fault_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) lex_byte(s_axis_tdata, s_axis_tlast);
    end
    pending_count = expected_tokens.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the markup token lexer testbench: stimulus, back-pressure, timeout and verdict.
module testbench;
  import mtl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CALM_ITEMS  = 200;   // closing stretch with no idling on either side
  localparam int RANDOM_ITEMS = 1750;

  typedef enum {TK_SEP, TK_NUM, TK_STR, TK_PUNCT} tk_class_t;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
  } in_item_t;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;    // [7:0] byte_in
  logic       s_axis_tlast;    // end_of_input
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;    // [7:0] token_char
  logic [4:0] m_axis_tuser;    // [2:0] token_kind, [4:3] error_code
  logic       m_axis_tlast;    // last_in_token

  int         pending_count;
  int         fault_count;
  int         cycle_count;
  bit         calm;
  in_item_t   byte_stream[$];

  markup_token_lexer dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  lexer_checker lexer_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .pending_count(pending_count),
    .fault_count  (fault_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("markup_token_lexer verification failed");
      $finish;
    end
  end

  // receiver: random stall bursts, always ready once calm
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_item(logic [7:0] b, logic eoi);
    in_item_t it;
    it.b   = b;
    it.eoi = eoi;
    byte_stream.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endtask

  // space, newline or an end-of-stream mark carrying a random byte
  task automatic add_separator();
    case ($urandom_range(0, 3))
      0:       add_item(CH_NL, 1'b0);
      1:       add_item(8'($urandom_range(0, 255)), 1'b1);
      default: add_item(CH_SPACE, 1'b0);
    endcase
  endtask

  initial begin : stimulus
    tk_class_t  prev_cls;
    tk_class_t  next_cls;
    bit         lead_minus;
    bit         joinable;
    logic [7:0] c;
    logic [7:0] punct[4];

    punct[0] = CH_LT;
    punct[1] = CH_GT;
    punct[2] = CH_QUOTE;
    punct[3] = CH_SLASH;

    rst           = 1'b1;
    calm          = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;

    // directed: lone minus, one-char tokens, lone zero, signed fraction, minus-dot
    // fraction, string with hyphen, tokens ended by other tokens, flushes in
    // and out of a token, end marks carrying high bytes
    add_text("-<0>-0.59 -.7AZ-\"9/");
    add_item(8'hFF, 1'b1);
    add_item(8'h80, 1'b1);
    add_text("B\n1");
    add_item(8'h55, 1'b1);

    // random: well-formed tokens, sometimes abutting where that cannot merge them
    prev_cls = TK_SEP;
    while (byte_stream.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       next_cls = TK_NUM;
        1:       next_cls = TK_STR;
        default: next_cls = TK_PUNCT;
      endcase
      lead_minus = (next_cls == TK_NUM) && ($urandom_range(0, 2) == 0);
      joinable = prev_cls == TK_SEP || prev_cls == TK_PUNCT || next_cls == TK_PUNCT ||
                 (prev_cls == TK_NUM && next_cls == TK_STR) ||
                 (prev_cls == TK_STR && next_cls == TK_NUM && !lead_minus);
      if (!joinable || $urandom_range(0, 3) == 0) begin
        add_separator();
        if ($urandom_range(0, 5) == 0) add_separator();
      end
      case (next_cls)
        TK_NUM: begin
          if (lead_minus) add_item(CH_MINUS, 1'b0);
          if (lead_minus && $urandom_range(0, 4) == 0) begin
            // lone minus, or minus straight into a fraction
            if ($urandom_range(0, 1)) begin
              add_item(CH_DOT, 1'b0);
              repeat ($urandom_range(1, 3))
                add_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            end
          end else begin
            if ($urandom_range(0, 2) == 0) begin
              add_item(CH_ZERO, 1'b0);
            end else begin
              add_item(CH_ZERO + 8'($urandom_range(1, 9)), 1'b0);
              repeat ($urandom_range(0, 4))
                add_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            end
            if ($urandom_range(0, 2) == 0) begin
              add_item(CH_DOT, 1'b0);
              repeat ($urandom_range(1, 3))
                add_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            end
          end
        end
        TK_STR: begin
          add_item(CH_UA + 8'($urandom_range(0, 25)), 1'b0);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) add_item(CH_MINUS, 1'b0);
            else add_item(CH_UA + 8'($urandom_range(0, 25)), 1'b0);
          end
        end
        default: add_item(punct[2'($urandom_range(0, 3))], 1'b0);
      endcase
      prev_cls = next_cls;
    end

    // finally one error of a random kind, then noise that the halted lexer ignores
    add_item(CH_SPACE, 1'b0);
    case ($urandom_range(0, 2))
      0: begin
        add_item(CH_ZERO, 1'b0);
        add_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      end
      1: begin
        add_item(CH_ZERO + 8'($urandom_range(1, 9)), 1'b0);
        add_item(CH_DOT, 1'b0);
        if ($urandom_range(0, 1)) begin
          add_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
          add_item(c, 1'b0);
        end
      end
      default: begin
        do c = 8'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UZ) ||
               c == CH_MINUS || c == CH_LT || c == CH_GT || c == CH_QUOTE ||
               c == CH_SLASH || c == CH_SPACE || c == CH_NL);
        add_item(c, 1'b0);
      end
    endcase
    repeat ($urandom_range(2, 6))
      add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < byte_stream.size(); i++) begin
      if (i >= byte_stream.size() - CALM_ITEMS) calm = 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= byte_stream[i].b;
      s_axis_tlast  <= byte_stream[i].eoi;
      do @(posedge clk); while (!s_axis_tready);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then wait for anything stray the block might still emit
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (fault_count == 0) begin
      $display("markup_token_lexer verification clean");
    end else begin
      $display("markup_token_lexer verification failed");
    end
    $finish;
  end

endmodule
